/* rtl/cpra_pkg.sv */
package cpra_pkg;

    localparam int PAGES = 4096;
    localparam int PG_W  = $clog2(PAGES);
    localparam int CNT_W = PG_W + 1;
    localparam int DIV_CNT_W = $clog2(PG_W + 1);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_SETUP  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
    localparam logic [OP_W-1:0] OP_PRIME1 = 4'd4;
    localparam logic [OP_W-1:0] OP_PRIME2 = 4'd5;
    localparam logic [OP_W-1:0] OP_WALK   = 4'd6;
    localparam logic [OP_W-1:0] OP_MARK   = 4'd7;
    localparam logic [OP_W-1:0] OP_FREE   = 4'd8;
    localparam logic [OP_W-1:0] OP_RSP    = 4'd9;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] page_count;
        logic [CNT_W-1:0] boundary;
        logic [PG_W-1:0]  limit_page;
        logic [PG_W-1:0]  release_start;
    } t_req;

    typedef struct packed {
        logic            ok;
        logic [PG_W-1:0] first_page;
    } t_rsp;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_done;
        logic is_release;
        logic req_bad;
        logic sw_zero;
        logic need_div;
        logic div_done;
        logic found;
        logic pass_fail;
        logic pass2;
        logic start_zero;
        logic rsp_free;
    } t_dp_sts;

endpackage

/* rtl/cpra_ifs.sv */
interface cpra_req_if;
    import cpra_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cpra_rsp_if;
    import cpra_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/cpra_ram.sv */
module cpra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/cpra_dp.sv */
module cpra_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cpra_pkg::t_dp_cmd      i_cmd,
    output cpra_pkg::t_dp_sts      o_sts,
    input  cpra_pkg::t_req         i_req_payload,
    input  logic                   i_cfg_wr_en,
    input  logic [cpra_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                   i_rsp_ready,
    output logic                   o_rsp_valid,
    output cpra_pkg::t_rsp         o_rsp_payload
);
    import cpra_pkg::*;

    t_req                 r_req;
    logic [CNT_W-1:0]     r_phys;
    logic [PG_W-1:0]      r_rover;
    logic [CNT_W-1:0]     r_last_cnt;
    logic [PG_W-1:0]      r_hi;
    logic [PG_W-1:0]      r_start;
    logic [CNT_W-1:0]     r_div_rem;
    logic [PG_W-1:0]      r_div_q;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [CNT_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_ph;
    logic                 r_in_run;
    logic [PG_W-1:0]      r_run_start;
    logic [CNT_W-1:0]     r_run_len;
    logic                 r_pass2;
    logic [PG_W-1:0]      r_sw_addr;
    logic [CNT_W-1:0]     r_sw_left;
    logic                 r_res_ok;
    logic [PG_W-1:0]      r_res_first;
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic [CNT_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_bnd;
    logic             w_no_align;
    logic [PG_W-1:0]  w_start_val;
    logic [PG_W-1:0]  w_np_m1;
    logic [PG_W-1:0]  w_hi_val;
    logic [CNT_W-1:0] w_rel_max;
    logic [CNT_W-1:0] w_rel_left;
    logic [CNT_W:0]   w_rem_sh;
    logic [CNT_W:0]   w_rem_sub;
    logic [CNT_W-1:0] n_rem;
    logic             w_used;
    logic             w_aligned;
    logic [CNT_W:0]   w_end_cand;
    logic             w_over;
    logic [CNT_W-1:0] w_len_inc;
    logic [CNT_W-1:0] w_ph_inc;
    logic [CNT_W-1:0] n_ph;
    logic [CNT_W-1:0] w_pos_inc;
    logic             w_found;
    logic             w_fail;
    logic             w_run_open;
    logic [PG_W-1:0]  w_first;
    logic [CNT_W-1:0] w_run_end;
    logic             w_wr_en;
    logic             w_wr_data;
    logic [PG_W-1:0]  w_rd_addr;
    logic             w_rd_data;

    assign w_cnt      = r_req.page_count;
    assign w_bnd      = r_req.boundary;
    assign w_no_align = (w_bnd[CNT_W-1:1] == '0);
    assign w_start_val = (w_cnt < r_last_cnt) ? '0 : r_rover;

    // highest usable page
    always_comb begin
        if (r_phys >= CNT_W'(PAGES)) begin
            w_np_m1 = PG_W'(PAGES - 1);
        end else begin
            w_np_m1 = PG_W'(r_phys - CNT_W'(1));
        end
        if (r_req.limit_page != '0 && r_req.limit_page < w_np_m1) begin
            w_hi_val = r_req.limit_page;
        end else begin
            w_hi_val = w_np_m1;
        end
    end

    assign w_rel_max  = CNT_W'(PAGES) - {1'b0, i_req_payload.release_start};
    assign w_rel_left = (i_req_payload.page_count < w_rel_max) ?
                        i_req_payload.page_count : w_rel_max;

    // restoring remainder step, one dividend bit per cycle
    assign w_rem_sh  = {r_div_rem, r_div_q[PG_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, w_bnd};
    assign n_rem     = (w_rem_sh >= {1'b0, w_bnd}) ? w_rem_sub[CNT_W-1:0] :
                       w_rem_sh[CNT_W-1:0];

    // page walk
    assign w_used     = w_rd_data;
    assign w_aligned  = w_no_align || (r_ph == '0);
    assign w_end_cand = {1'b0, r_pos} + {1'b0, w_cnt} - (CNT_W+1)'(1);
    assign w_over     = (r_pos > {1'b0, r_hi}) || (r_pass2 && r_pos >= {1'b0, r_start});
    assign w_len_inc  = r_run_len + CNT_W'(1);
    assign w_ph_inc   = r_ph + CNT_W'(1);
    assign n_ph       = (w_ph_inc == w_bnd) ? '0 : w_ph_inc;
    assign w_pos_inc  = r_pos + CNT_W'(1);

    always_comb begin
        w_found    = 1'b0;
        w_fail     = 1'b0;
        w_run_open = 1'b0;
        w_first    = r_run_start;
        if (r_in_run) begin
            if (!w_used && w_len_inc == w_cnt) begin
                w_found = 1'b1;
            end
        end else if (w_over) begin
            w_fail = 1'b1;
        end else if (w_aligned) begin
            if (w_end_cand > {2'b0, r_hi}) begin
                w_fail = 1'b1;
            end else if (!w_used) begin
                if (w_cnt == CNT_W'(1)) begin
                    w_found = 1'b1;
                    w_first = r_pos[PG_W-1:0];
                end else begin
                    w_run_open = 1'b1;
                end
            end
        end
    end

    assign w_run_end = {1'b0, w_first} + w_cnt;

    // free map port
    assign w_wr_en   = (i_cmd.op == OP_MARK) || (i_cmd.op == OP_FREE);
    assign w_wr_data = (i_cmd.op == OP_MARK);

    always_comb begin
        unique case (i_cmd.op)
            OP_PRIME1: w_rd_addr = r_start;
            OP_PRIME2: w_rd_addr = '0;
            default:   w_rd_addr = w_pos_inc[PG_W-1:0];
        endcase
    end

    cpra_ram #(
        .WIDTH (1),
        .DEPTH (PAGES)
    ) u_free_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_sw_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys      <= CNT_W'(PAGES);
            r_rover     <= '0;
            r_last_cnt  <= '0;
            r_sw_addr   <= '0;
            r_sw_left   <= CNT_W'(PAGES);
            r_out_valid <= 1'b0;
            r_in_run    <= 1'b0;
            r_pass2     <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_phys <= i_cfg_wr_data;
            end
            if (i_cmd.op == OP_RSP) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    if (i_req_payload.cmd == CMD_RELEASE) begin
                        r_sw_addr <= i_req_payload.release_start;
                        r_sw_left <= w_rel_left;
                    end
                end
                OP_SETUP: begin
                    r_last_cnt <= w_cnt;
                    r_rover    <= w_start_val;
                    r_div_cnt  <= DIV_CNT_W'(PG_W);
                end
                OP_DIV: begin
                    r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                end
                OP_PRIME1: begin
                    r_in_run <= 1'b0;
                    r_pass2  <= 1'b0;
                end
                OP_PRIME2: begin
                    r_in_run <= 1'b0;
                    r_pass2  <= 1'b1;
                end
                OP_WALK: begin
                    if (r_in_run) begin
                        if (w_used) begin
                            r_in_run <= 1'b0;
                        end
                    end else if (w_run_open) begin
                        r_in_run <= 1'b1;
                    end
                    if (w_found) begin
                        r_rover   <= w_run_end[PG_W-1:0];
                        r_sw_addr <= w_first;
                        r_sw_left <= w_cnt;
                    end
                end
                OP_MARK, OP_FREE: begin
                    r_sw_addr <= r_sw_addr + PG_W'(1);
                    r_sw_left <= r_sw_left - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_req       <= i_req_payload;
                r_res_ok    <= (i_req_payload.cmd == CMD_RELEASE);
                r_res_first <= (i_req_payload.cmd == CMD_RELEASE) ?
                               i_req_payload.release_start : '0;
            end
            OP_SETUP: begin
                r_start   <= w_start_val;
                r_hi      <= w_hi_val;
                r_div_rem <= '0;
                r_div_q   <= w_start_val;
            end
            OP_DIV: begin
                r_div_rem <= n_rem;
                r_div_q   <= {r_div_q[PG_W-2:0], 1'b0};
            end
            OP_PRIME1: begin
                r_pos <= {1'b0, r_start};
                r_ph  <= r_div_rem;
            end
            OP_PRIME2: begin
                r_pos <= '0;
                r_ph  <= '0;
            end
            OP_WALK: begin
                r_pos <= w_pos_inc;
                r_ph  <= n_ph;
                if (r_in_run) begin
                    r_run_len <= w_len_inc;
                end else if (w_run_open) begin
                    r_run_start <= r_pos[PG_W-1:0];
                    r_run_len   <= CNT_W'(1);
                end
                if (w_found) begin
                    r_res_ok    <= 1'b1;
                    r_res_first <= w_first;
                end
            end
            OP_RSP: begin
                r_out.ok         <= r_res_ok;
                r_out.first_page <= r_res_first;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_rsp_payload = r_out;

    assign o_sts.sweep_done = (r_sw_left == CNT_W'(1));
    assign o_sts.is_release = (r_req.cmd == CMD_RELEASE);
    assign o_sts.req_bad    = (w_cnt == '0) || (r_phys == '0);
    assign o_sts.sw_zero    = (r_sw_left == '0);
    assign o_sts.need_div   = !w_no_align && (w_start_val != '0);
    assign o_sts.div_done   = (r_div_cnt == DIV_CNT_W'(1));
    assign o_sts.found      = w_found;
    assign o_sts.pass_fail  = w_fail;
    assign o_sts.pass2      = r_pass2;
    assign o_sts.start_zero = (r_start == '0);
    assign o_sts.rsp_free   = !r_out_valid || i_rsp_ready;
endmodule

/* rtl/cpra_ctrl.sv */
module cpra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  cpra_pkg::t_dp_sts i_sts,
    output cpra_pkg::t_dp_cmd o_cmd
);
    import cpra_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_PRIME1 = 4'd4;
    localparam logic [3:0] S_PRIME2 = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_MARK   = 4'd7;
    localparam logic [3:0] S_FREE   = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_FREE;
                if (i_sts.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_release) begin
                    n_state = i_sts.sw_zero ? S_RESP : S_FREE;
                end else if (i_sts.req_bad) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.op = OP_SETUP;
                    n_state  = i_sts.need_div ? S_DIV : S_PRIME1;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) begin
                    n_state = S_PRIME1;
                end
            end
            S_PRIME1: begin
                o_cmd.op = OP_PRIME1;
                n_state  = S_WALK;
            end
            S_PRIME2: begin
                o_cmd.op = OP_PRIME2;
                n_state  = S_WALK;
            end
            S_WALK: begin
                o_cmd.op = OP_WALK;
                if (i_sts.found) begin
                    n_state = S_MARK;
                end else if (i_sts.pass_fail) begin
                    n_state = (i_sts.pass2 || i_sts.start_zero) ? S_RESP : S_PRIME2;
                end
            end
            S_MARK: begin
                o_cmd.op = OP_MARK;
                if (i_sts.sweep_done) begin
                    n_state = S_RESP;
                end
            end
            S_FREE: begin
                o_cmd.op = OP_FREE;
                if (i_sts.sweep_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.rsp_free) begin
                    o_cmd.op = OP_RSP;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

/* rtl/contiguous_page_run_allocator.sv */
// one request at a time; a request is taken only while the block is idle
// release: one free map write per page, the count clipped at the last page of the map
// allocate: decode and setup, up to 12 remainder steps, then one page per cycle over at most
// two scans of the map (each after a priming step), then one write per allocated page
// reset: synchronous; a clearing pass over all 4096 pages of the free map runs before
// the first request is taken, configuration writes are taken throughout
module contiguous_page_run_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [cpra_pkg::CNT_W-1:0] i_cfg_wr_data,
    cpra_req_if.sink                   i_req,
    cpra_rsp_if.source                 o_rsp
);
    import cpra_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cpra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cpra_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_payload (i_req.payload),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp_payload (o_rsp.payload)
    );
endmodule

/* rtl/cpra_checker.sv */
module cpra_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input cpra_pkg::t_rsp i_rsp_payload
);
    import cpra_pkg::*;

    a_rsp_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request taken during clearing pass");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while busy");

    a_fail_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_payload.ok |-> i_rsp_payload.first_page == '0)
        else $error("failed allocation with nonzero page");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("stalled response changed");
endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
